@@ sv/pce_pkg.sv @@
// Shared types and constants for the postfix constant evaluator.
// Holds opcode and kind codes, stack entry layout, and the controller/datapath bundles.
// No dependencies.
`default_nettype none

package pce_pkg;

    localparam int WORD_W = 32;
    localparam int PCE_STACK_DEPTH = 16;

    typedef enum logic [3:0] {
        OP_PUSH_NUM  = 4'd0,
        OP_PUSH_BOOL = 4'd1,
        OP_AND       = 4'd2,
        OP_OR        = 4'd3,
        OP_EQ        = 4'd4,
        OP_NE        = 4'd5,
        OP_ADD       = 4'd6,
        OP_SUB       = 4'd7,
        OP_MUL       = 4'd8,
        OP_DIV       = 4'd9,
        OP_MOD       = 4'd10,
        OP_NOT       = 4'd11,
        OP_NEG       = 4'd12,
        OP_UNSUP     = 4'd13
    } op_t;

    typedef enum logic [1:0] {
        KIND_BOOL = 2'd0,
        KIND_NUM  = 2'd1,
        KIND_NONE = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_R,
        S_RD_L,
        S_EXEC,
        S_DIV,
        S_FIN,
        S_RD_TOP,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic              is_bool;
        logic [WORD_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic load_in;
        logic set_fail;
        logic wr_lit;
        logic rd_second;
        logic cap_r;
        logic cap_l;
        logic div_start;
        logic wr_res;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic last;
        logic failed;
        logic h_zero;
        logic h_lt2;
        logic full;
        logic lit_bad;
        logic type_ok;
        logic r_zero;
        logic div_busy;
        logic out_free;
    } stat_t;

    function automatic logic is_binary(input op_t op);
        logic b;
        case (op)
            OP_AND, OP_OR, OP_EQ, OP_NE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: b = 1'b1;
            default: b = 1'b0;
        endcase
        return b;
    endfunction

    function automatic logic is_unary(input op_t op);
        return (op == OP_NOT) || (op == OP_NEG);
    endfunction

endpackage

`default_nettype wire

@@ sv/pce_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the operand stack.
`default_nettype none

module pce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ sv/pce_div.sv @@
// Restoring divider, one quotient bit per cycle, for div and mod tokens.
// Depends on pce_pkg for the word width.
`default_nettype none

module pce_div
    import pce_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] dividend,
    input  wire logic [WORD_W-1:0] divisor,
    output logic                   busy,
    output logic      [WORD_W-1:0] quotient,
    output logic      [WORD_W-1:0] remainder
);

    localparam int CW = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [WORD_W-1:0] quot_reg, quot_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvsr_reg, dvsr_next;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   diff;

    assign rem_shift = {rem_reg, quot_reg[WORD_W-1]};
    assign diff      = rem_shift - {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dvsr_next  = dvsr_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CW'(WORD_W - 1);
            quot_next  = dividend;
            rem_next   = '0;
            dvsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // A borrow out of the trial subtraction means this quotient bit is zero.
            if (!diff[WORD_W])
            begin
                rem_next = diff[WORD_W-1:0];
            end
            else
            begin
                rem_next = rem_shift[WORD_W-1:0];
            end
            quot_next  = {quot_reg[WORD_W-2:0], !diff[WORD_W]};
            count_next = count_reg - CW'(1);
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ sv/pce_ctrl.sv @@
// Token sequencer for the postfix constant evaluator.
// Depends on pce_pkg; drives the datapath through cmd_t and reads stat_t.
`default_nettype none

module pce_ctrl
    import pce_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   div_op;

    assign div_op = (stat.op == OP_DIV) || (stat.op == OP_MOD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = stat.last ? S_FIN : S_IDLE;
                if (!stat.failed)
                begin
                    if (is_binary(stat.op) && !stat.h_lt2)
                    begin
                        state_next = S_RD_R;
                    end
                    else if (is_unary(stat.op) && !stat.h_zero)
                    begin
                        state_next = S_RD_R;
                    end
                end
            end
            S_RD_R:
            begin
                state_next = is_binary(stat.op) ? S_RD_L : S_EXEC;
            end
            S_RD_L:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.type_ok && div_op && !stat.r_zero)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = stat.last ? S_FIN : S_IDLE;
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = stat.last ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                state_next = (stat.failed || stat.h_zero) ? S_RESULT : S_RD_TOP;
            end
            S_RD_TOP:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_DECODE:
            begin
                if (!stat.failed)
                begin
                    case (stat.op)
                        OP_PUSH_NUM:
                        begin
                            cmd.set_fail = stat.full;
                            cmd.wr_lit   = !stat.full;
                        end
                        OP_PUSH_BOOL:
                        begin
                            cmd.set_fail = stat.full || stat.lit_bad;
                            cmd.wr_lit   = !(stat.full || stat.lit_bad);
                        end
                        OP_AND, OP_OR, OP_EQ, OP_NE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                        begin
                            cmd.set_fail = stat.h_lt2;
                        end
                        OP_NOT, OP_NEG:
                        begin
                            cmd.set_fail = stat.h_zero;
                        end
                        default:
                        begin
                            cmd.set_fail = 1'b1;
                        end
                    endcase
                end
            end
            S_RD_R:
            begin
                cmd.cap_r     = 1'b1;
                cmd.rd_second = 1'b1;
            end
            S_RD_L:
            begin
                cmd.cap_l = 1'b1;
            end
            S_EXEC:
            begin
                if (!stat.type_ok || (div_op && stat.r_zero))
                begin
                    cmd.set_fail = 1'b1;
                end
                else if (div_op)
                begin
                    cmd.div_start = 1'b1;
                end
                else
                begin
                    cmd.wr_res = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.wr_res = !stat.div_busy;
            end
            S_FIN:
            begin
            end
            S_RD_TOP:
            begin
                cmd.cap_r = 1'b1;
            end
            S_RESULT:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/pce_dp.sv @@
// Datapath: token registers, operand stack, ALU, divider and output register.
// Depends on pce_pkg, pce_ram and pce_div; controlled through cmd_t.
`default_nettype none

module pce_dp
    import pce_pkg::*;
#(
    parameter int STACK_DEPTH = PCE_STACK_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [3:0]        opcode,
    input  wire logic [WORD_W-1:0] literal_value,
    input  wire logic              last_token,
    output logic      [1:0]        result_kind,
    output logic      [WORD_W-1:0] result_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire cmd_t              cmd,
    output stat_t                  stat
);

    localparam int HW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int EW = WORD_W + 1;

    op_t               op_reg;
    logic [WORD_W-1:0] lit_reg;
    logic              last_reg;
    logic [HW-1:0]     height_reg, height_next;
    logic              failed_reg, failed_next;
    entry_t            r_reg;
    entry_t            l_reg;
    kind_t             out_kind_reg;
    logic [WORD_W-1:0] out_value_reg;
    logic              out_valid_reg, out_valid_next;

    logic [HW-1:0]     h_m1;
    logic [HW-1:0]     h_m2;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    entry_t            ram_wdata;
    logic [EW-1:0]     ram_rdata;
    entry_t            rd_entry;
    entry_t            alu_res;
    entry_t            res_entry;
    logic              type_ok;
    logic              div_busy;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
    logic              no_result;

    assign h_m1     = height_reg - HW'(1);
    assign h_m2     = height_reg - HW'(2);
    assign rd_entry = entry_t'(ram_rdata);

    // Type rules per operator; a failing check poisons the whole expression.
    always_comb
    begin
        case (op_reg)
            OP_AND, OP_OR:                           type_ok = l_reg.is_bool && r_reg.is_bool;
            OP_EQ, OP_NE:                            type_ok = l_reg.is_bool == r_reg.is_bool;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:  type_ok = !l_reg.is_bool && !r_reg.is_bool;
            OP_NOT:                                  type_ok = r_reg.is_bool;
            OP_NEG:                                  type_ok = !r_reg.is_bool;
            default:                                 type_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        alu_res = '0;
        case (op_reg)
            OP_AND:
            begin
                alu_res.is_bool = 1'b1;
                alu_res.value   = WORD_W'((l_reg.value != '0) && (r_reg.value != '0));
            end
            OP_OR:
            begin
                alu_res.is_bool = 1'b1;
                alu_res.value   = WORD_W'((l_reg.value != '0) || (r_reg.value != '0));
            end
            OP_EQ:
            begin
                alu_res.is_bool = 1'b1;
                alu_res.value   = WORD_W'(l_reg.value == r_reg.value);
            end
            OP_NE:
            begin
                alu_res.is_bool = 1'b1;
                alu_res.value   = WORD_W'(l_reg.value != r_reg.value);
            end
            OP_ADD:  alu_res.value = l_reg.value + r_reg.value;
            OP_SUB:  alu_res.value = l_reg.value - r_reg.value;
            OP_MUL:  alu_res.value = WORD_W'(l_reg.value * r_reg.value);
            OP_NOT:
            begin
                alu_res.is_bool = 1'b1;
                alu_res.value   = WORD_W'(r_reg.value == '0);
            end
            OP_NEG:  alu_res.value = '0 - r_reg.value;
            default: alu_res = '0;
        endcase
    end

    always_comb
    begin
        res_entry = alu_res;
        case (op_reg)
            OP_DIV:  res_entry = '{is_bool: 1'b0, value: quotient};
            OP_MOD:  res_entry = '{is_bool: 1'b0, value: remainder};
            default: res_entry = alu_res;
        endcase
    end

    // A binary result lands where its left operand was; a unary one replaces the top.
    always_comb
    begin
        ram_we    = cmd.wr_lit || cmd.wr_res;
        ram_raddr = cmd.rd_second ? h_m2[AW-1:0] : h_m1[AW-1:0];
        if (cmd.wr_lit)
        begin
            ram_waddr = height_reg[AW-1:0];
            ram_wdata = '{is_bool: (op_reg == OP_PUSH_BOOL), value: lit_reg};
        end
        else
        begin
            ram_waddr = is_binary(op_reg) ? h_m2[AW-1:0] : h_m1[AW-1:0];
            ram_wdata = res_entry;
        end
    end

    pce_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    pce_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (l_reg.value),
        .divisor   (r_reg.value),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_comb
    begin
        height_next = height_reg;
        failed_next = failed_reg;
        if (cmd.load_out)
        begin
            height_next = '0;
            failed_next = 1'b0;
        end
        else
        begin
            if (cmd.wr_lit)
            begin
                height_next = height_reg + HW'(1);
            end
            else if (cmd.wr_res && is_binary(op_reg))
            begin
                height_next = h_m1;
            end
            if (cmd.set_fail)
            begin
                failed_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg    <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            height_reg    <= height_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign no_result = failed_reg || (height_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= op_t'(opcode);
            lit_reg  <= literal_value;
            last_reg <= last_token;
        end
        if (cmd.cap_r)
        begin
            r_reg <= rd_entry;
        end
        if (cmd.cap_l)
        begin
            l_reg <= rd_entry;
        end
        if (cmd.load_out)
        begin
            if (no_result)
            begin
                out_kind_reg  <= KIND_NONE;
                out_value_reg <= '0;
            end
            else
            begin
                out_kind_reg  <= r_reg.is_bool ? KIND_BOOL : KIND_NUM;
                out_value_reg <= r_reg.value;
            end
        end
    end

    always_comb
    begin
        stat          = '0;
        stat.op       = op_reg;
        stat.last     = last_reg;
        stat.failed   = failed_reg;
        stat.h_zero   = height_reg == '0;
        stat.h_lt2    = height_reg < HW'(2);
        stat.full     = height_reg == HW'(STACK_DEPTH);
        stat.lit_bad  = lit_reg > WORD_W'(1);
        stat.type_ok  = type_ok;
        stat.r_zero   = r_reg.value == '0;
        stat.div_busy = div_busy;
        stat.out_free = !out_valid_reg || out_ready;
    end

    assign result_kind  = out_kind_reg;
    assign result_value = out_value_reg;
    assign out_valid    = out_valid_reg;

endmodule

`default_nettype wire

@@ sv/postfix_constant_evaluator.sv @@
// Top level of the postfix constant evaluator: sequencer plus datapath.
// Depends on pce_pkg, pce_ctrl and pce_dp.
//
//   channel   handshake             payload
//   token     in_valid / in_ready   opcode, literal_value, last_token
//   result    out_valid / out_ready result_kind, result_value
//
// A push word needs only the idle and decode states; an operator reads its operands
// one at a time through the single registered read port of the stack RAM; div and mod
// wait in S_DIV on the bit-serial divider. A last word then reads the top if constant.
// Reset clears the stack height, the failure flag and out_valid; the stack RAM and the
// result are not cleared. A result waiting on out_ready holds the next one in S_RESULT.
`default_nettype none

module postfix_constant_evaluator
    import pce_pkg::*;
#(
    parameter int STACK_DEPTH = PCE_STACK_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [3:0]        opcode,
    input  wire logic [WORD_W-1:0] literal_value,
    input  wire logic              last_token,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [1:0]        result_kind,
    output logic      [WORD_W-1:0] result_value
);

    cmd_t  cmd;
    stat_t stat;

    pce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pce_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .opcode        (opcode),
        .literal_value (literal_value),
        .last_token    (last_token),
        .result_kind   (result_kind),
        .result_value  (result_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

`default_nettype wire
